// ===== rtl/bgra_pkg.sv =====
// bgra_pkg: shared types and constants for the block gain ramp amplifier
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package bgra_pkg;

    localparam int MAX_BLOCK    = 4096;
    localparam int MAX_CHANNELS = 64;
    localparam int SAMPLE_BITS  = 24;

    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 13;
    localparam int CH_W     = 7;
    localparam int POS_W    = $clog2(MAX_BLOCK);
    localparam int CPOS_W   = $clog2(MAX_CHANNELS);
    localparam int FRAC_X   = 16;
    localparam int RAMP_W   = GAIN_W + FRAC_X + 1;
    localparam int PROD_W   = SAMPLE_BITS + RAMP_W;
    localparam int OUT_SHR  = 28;
    localparam int DIFF_W   = GAIN_W + 1;
    localparam int DVD_W    = GAIN_W + FRAC_X;
    localparam int REM_W    = LEN_W;
    localparam int DCNT_W   = $clog2(DVD_W);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sd4096;
    localparam logic [LEN_W-1:0]         LEN_RESET   = 13'd256;
    localparam logic [CH_W-1:0]          CH_RESET    = 7'd2;

    localparam logic signed [PROD_W-1:0] SAT_MAX =
        PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN     = 2'd0;
    localparam logic [1:0] CFG_MUTED    = 2'd1;
    localparam logic [1:0] CFG_BLOCKLEN = 2'd2;
    localparam logic [1:0] CFG_CHANNELS = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [GAIN_W-1:0]      gain;
        logic [LEN_W-1:0]              len;
        logic                          first_blk;
        logic                          first_ch;
        logic                          last_blk;
        logic                          silenced;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] diff;
        logic [LEN_W-1:0]         len;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [RAMP_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } t_back_state;

endpackage

// ===== rtl/bgra_fifo.sv =====
// bgra_fifo: small register queue between the front classifier and the back datapath
// depends on bgra_pkg
`timescale 1ns / 1ps

module bgra_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bgra_pkg::t_entry      i_wdata,
    input  logic                  i_pop,
    output bgra_pkg::t_entry      o_rdata,
    output bgra_pkg::t_fifo_status o_status
);

    bgra_pkg::t_entry r_mem [bgra_pkg::FIFO_DEPTH];
    logic [bgra_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [bgra_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [bgra_pkg::FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == bgra_pkg::FIFO_CNT_W'(bgra_pkg::FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bgra_pkg::FIFO_CNT_W'(bgra_pkg::FIFO_DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push was lost");

endmodule

// ===== rtl/bgra_div.sv =====
// bgra_div: restoring divider for the per-block ramp step, one quotient bit per cycle
// depends on bgra_pkg
`timescale 1ns / 1ps

module bgra_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgra_pkg::t_div_req i_req,
    output bgra_pkg::t_div_rsp o_rsp
);

    bgra_pkg::t_div_state r_state, n_state;

    logic [bgra_pkg::DVD_W-1:0]  r_dvd;
    logic [bgra_pkg::REM_W-1:0]  r_rem;
    logic [bgra_pkg::LEN_W-1:0]  r_den;
    logic                        r_neg;
    logic [bgra_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_done, n_done;

    logic [bgra_pkg::GAIN_W-1:0] mag;
    logic [bgra_pkg::DIFF_W-1:0] diff_abs;
    logic [bgra_pkg::REM_W:0]    rem_sh;
    logic                        qbit;

    assign diff_abs = i_req.diff[bgra_pkg::DIFF_W-1] ? bgra_pkg::DIFF_W'(-i_req.diff)
                                                     : bgra_pkg::DIFF_W'(i_req.diff);
    assign mag      = diff_abs[bgra_pkg::GAIN_W-1:0];
    assign rem_sh   = {r_rem, r_dvd[bgra_pkg::DVD_W-1]};
    assign qbit     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgra_pkg::DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            bgra_pkg::DIV_IDLE: begin
                if (i_req.start) begin
                    n_state = bgra_pkg::DIV_RUN;
                end
            end
            bgra_pkg::DIV_RUN: begin
                if (r_cnt == '0) begin
                    n_state = bgra_pkg::DIV_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = bgra_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bgra_pkg::DIV_IDLE) begin
            if (i_req.start) begin
                r_dvd <= {mag, bgra_pkg::FRAC_X'(0)};
                r_rem <= '0;
                r_den <= i_req.len;
                r_neg <= i_req.diff[bgra_pkg::DIFF_W-1];
                r_cnt <= bgra_pkg::DCNT_W'(bgra_pkg::DVD_W - 1);
            end
        end else begin
            r_rem <= qbit ? bgra_pkg::REM_W'(rem_sh - {1'b0, r_den})
                          : rem_sh[bgra_pkg::REM_W-1:0];
            r_dvd <= {r_dvd[bgra_pkg::DVD_W-2:0], qbit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient truncates toward zero: magnitude divide, then restore the sign
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -bgra_pkg::RAMP_W'({1'b0, r_dvd})
                              :  bgra_pkg::RAMP_W'({1'b0, r_dvd});

endmodule

// ===== rtl/bgra_front.sv =====
// bgra_front: configuration registers, block and channel counters, silencing flags
// depends on bgra_pkg; feeds classified samples into bgra_fifo
`timescale 1ns / 1ps

module bgra_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [1:0]                          i_cfg_index,
    input  logic [bgra_pkg::GAIN_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    input  logic signed [bgra_pkg::SAMPLE_BITS-1:0] i_in_sample,
    input  logic                                i_input_absent,
    input  logic                                i_fifo_full,
    output logic                                o_push,
    output bgra_pkg::t_entry                    o_entry
);

    logic signed [bgra_pkg::GAIN_W-1:0] r_gain;
    logic                               r_muted;
    logic [bgra_pkg::LEN_W-1:0]         r_cfg_len;
    logic [bgra_pkg::CH_W-1:0]          r_cfg_ch;

    logic [bgra_pkg::LEN_W-1:0]  r_len;
    logic [bgra_pkg::CH_W-1:0]   r_ch;
    logic [bgra_pkg::POS_W-1:0]  r_sp;
    logic [bgra_pkg::CPOS_W-1:0] r_cp;
    logic                        r_sil;

    logic                        first_blk;
    logic                        first_ch;
    logic [bgra_pkg::LEN_W-1:0]  len_clamp, len_eff;
    logic [bgra_pkg::CH_W-1:0]   ch_clamp, ch_eff;
    logic                        sil_cur;
    logic                        last_ch;
    logic                        last_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= bgra_pkg::GAIN_RESET;
            r_muted   <= 1'b0;
            r_cfg_len <= bgra_pkg::LEN_RESET;
            r_cfg_ch  <= bgra_pkg::CH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bgra_pkg::CFG_GAIN:     r_gain    <= i_cfg_data;
                bgra_pkg::CFG_MUTED:    r_muted   <= i_cfg_data[0];
                bgra_pkg::CFG_BLOCKLEN: r_cfg_len <= i_cfg_data[bgra_pkg::LEN_W-1:0];
                bgra_pkg::CFG_CHANNELS: r_cfg_ch  <= i_cfg_data[bgra_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_len == '0) begin
            len_clamp = bgra_pkg::LEN_W'(1);
        end else if (r_cfg_len > bgra_pkg::LEN_W'(bgra_pkg::MAX_BLOCK)) begin
            len_clamp = bgra_pkg::LEN_W'(bgra_pkg::MAX_BLOCK);
        end else begin
            len_clamp = r_cfg_len;
        end
        if (r_cfg_ch == '0) begin
            ch_clamp = bgra_pkg::CH_W'(1);
        end else if (r_cfg_ch > bgra_pkg::CH_W'(bgra_pkg::MAX_CHANNELS)) begin
            ch_clamp = bgra_pkg::CH_W'(bgra_pkg::MAX_CHANNELS);
        end else begin
            ch_clamp = r_cfg_ch;
        end
    end

    assign o_push    = i_in_valid && !i_fifo_full;
    assign first_ch  = (r_sp == '0);
    assign first_blk = first_ch && (r_cp == '0);
    assign len_eff   = first_blk ? len_clamp : r_len;
    assign ch_eff    = first_blk ? ch_clamp  : r_ch;
    // absent flag only counts on a channel's first sample and sticks to block end
    assign sil_cur   = (first_blk ? r_muted : r_sil) | (first_ch & i_input_absent);
    assign last_ch   = (bgra_pkg::LEN_W'(r_sp) + 1'b1) == len_eff;
    assign last_blk  = last_ch && ((bgra_pkg::CH_W'(r_cp) + 1'b1) == ch_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= bgra_pkg::LEN_W'(1);
            r_ch  <= bgra_pkg::CH_W'(1);
            r_sp  <= '0;
            r_cp  <= '0;
            r_sil <= 1'b0;
        end else if (o_push) begin
            r_len <= len_eff;
            r_ch  <= ch_eff;
            r_sil <= last_blk ? 1'b0 : sil_cur;
            if (last_ch) begin
                r_sp <= '0;
                r_cp <= last_blk ? '0 : r_cp + 1'b1;
            end else begin
                r_sp <= r_sp + 1'b1;
            end
        end
    end

    assign o_entry.sample    = i_in_sample;
    assign o_entry.gain      = r_gain;
    assign o_entry.len       = len_eff;
    assign o_entry.first_blk = first_blk;
    assign o_entry.first_ch  = first_ch;
    assign o_entry.last_blk  = last_blk;
    assign o_entry.silenced  = sil_cur;

endmodule

// ===== rtl/bgra_back.sv =====
// bgra_back: ramp step sequencing, gain multiply, floor shift, saturation and silencing
// depends on bgra_pkg and bgra_div; pops entries from bgra_fifo
`timescale 1ns / 1ps

module bgra_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bgra_pkg::t_entry                     i_head,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bgra_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                                 o_last_of_block
);

    bgra_pkg::t_back_state r_state, n_state;

    logic                                r_step_ready;
    logic signed [bgra_pkg::RAMP_W-1:0]  r_step;
    logic signed [bgra_pkg::RAMP_W-1:0]  r_ramp;
    logic signed [bgra_pkg::GAIN_W-1:0]  r_prev;
    logic signed [bgra_pkg::GAIN_W-1:0]  r_gain;

    logic                                r_p_valid;
    logic signed [bgra_pkg::PROD_W-1:0]  r_prod;
    logic                                r_p_sil;
    logic                                r_p_last;

    logic                                r_out_valid;
    logic signed [bgra_pkg::SAMPLE_BITS-1:0] r_out_sample;
    logic                                r_out_last;

    bgra_pkg::t_div_req                  div_req;
    bgra_pkg::t_div_rsp                  div_rsp;

    logic                                out_adv;
    logic                                p_adv;
    logic                                pop;
    logic signed [bgra_pkg::GAIN_W-1:0]  eff_gain;
    logic signed [bgra_pkg::RAMP_W-1:0]  prev_q;
    logic signed [bgra_pkg::RAMP_W-1:0]  g_base;
    logic signed [bgra_pkg::PROD_W-1:0]  shifted;
    logic signed [bgra_pkg::SAMPLE_BITS-1:0] sat;

    bgra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_adv  = !r_out_valid || !i_out_stall;
    assign p_adv    = !r_p_valid || out_adv;
    assign eff_gain = i_head.first_blk ? i_head.gain : r_gain;
    assign prev_q   = {r_prev[bgra_pkg::GAIN_W-1], r_prev, bgra_pkg::FRAC_X'(0)};
    // with equal gains the step is zero, so the ramp holds the flat gain
    assign g_base   = i_head.first_ch ? prev_q : r_ramp;

    assign div_req.diff = bgra_pkg::DIFF_W'(i_head.gain) - bgra_pkg::DIFF_W'(r_prev);
    assign div_req.len  = i_head.len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgra_pkg::BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        pop           = 1'b0;
        unique case (r_state)
            bgra_pkg::BK_RUN: begin
                if (!i_empty) begin
                    if (i_head.first_blk && !r_step_ready) begin
                        div_req.start = 1'b1;
                        n_state       = bgra_pkg::BK_DIV;
                    end else begin
                        pop = p_adv;
                    end
                end
            end
            bgra_pkg::BK_DIV: begin
                if (div_rsp.done) begin
                    n_state = bgra_pkg::BK_RUN;
                end
            end
            default: n_state = bgra_pkg::BK_RUN;
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ready <= 1'b0;
            r_step       <= '0;
            r_prev       <= '0;
            r_gain       <= '0;
            r_p_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == bgra_pkg::BK_DIV && div_rsp.done) begin
                r_step       <= div_rsp.quo;
                r_step_ready <= 1'b1;
            end else if (pop && i_head.first_blk) begin
                r_step_ready <= 1'b0;
            end
            if (pop) begin
                if (i_head.first_blk) begin
                    r_gain <= i_head.gain;
                end
                if (i_head.last_blk) begin
                    r_prev <= eff_gain;
                end
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ramp   <= g_base + r_step;
            r_prod   <= bgra_pkg::PROD_W'(i_head.sample) * bgra_pkg::PROD_W'(g_base);
            r_p_sil  <= i_head.silenced;
            r_p_last <= i_head.last_blk;
        end
    end

    // floor by arithmetic shift, then clip to the sample range
    assign shifted = r_prod >>> bgra_pkg::OUT_SHR;

    always_comb begin
        if (r_p_sil) begin
            sat = '0;
        end else if (shifted > bgra_pkg::SAT_MAX) begin
            sat = bgra_pkg::SAMPLE_BITS'(bgra_pkg::SAT_MAX);
        end else if (shifted < bgra_pkg::SAT_MIN) begin
            sat = bgra_pkg::SAMPLE_BITS'(bgra_pkg::SAT_MIN);
        end else begin
            sat = bgra_pkg::SAMPLE_BITS'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_p_valid) begin
            r_out_sample <= sat;
            r_out_last   <= r_p_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_last_of_block = r_out_last;

    a_step_before_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_head.first_blk) |-> r_step_ready)
        else $error("block started without a fresh ramp step");

    a_step_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_head.first_blk) |=> !r_step_ready)
        else $error("ramp step reused across blocks");

    a_prev_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_head.last_blk) |=> (r_prev == $past(eff_gain)))
        else $error("previous gain not taken at block end");

endmodule

// ===== rtl/block_gain_ramp_amplifier.sv =====
// block_gain_ramp_amplifier: top level of the multichannel gain stage with ramp smoothing
// depends on bgra_pkg, bgra_front, bgra_fifo, bgra_back (which holds bgra_div)
`timescale 1ns / 1ps

// Samples stream in channel by channel, one per cycle in steady state while
// the output is not stalled; each passes the queue, the product register and
// the output register on its way from input request to output request. At the
// first sample of every block the back end computes the ramp step with a
// bit-serial divider, which holds that sample until the step is ready; the
// front end keeps accepting into a four-entry queue meanwhile. Gain, mute,
// block length and channel count are sampled at each block start; writes
// are taken at any time (ready is always high) and apply from the next block.

module block_gain_ramp_amplifier (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [bgra_pkg::SAMPLE_BITS-1:0] i_in_sample,
    input  logic                                    i_input_absent,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [bgra_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                                    o_last_of_block,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [1:0]                              i_cfg_index,
    input  logic [bgra_pkg::GAIN_W-1:0]             i_cfg_data
);

    bgra_pkg::t_entry       push_entry;
    bgra_pkg::t_entry       head_entry;
    bgra_pkg::t_fifo_status fifo_status;
    logic                   push;
    logic                   pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = fifo_status.full;

    bgra_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_sample    (i_in_sample),
        .i_input_absent (i_input_absent),
        .i_fifo_full    (fifo_status.full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    bgra_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_entry),
        .i_pop    (pop),
        .o_rdata  (head_entry),
        .o_status (fifo_status)
    );

    bgra_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_entry),
        .i_empty         (fifo_status.empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_sample    (o_out_sample),
        .o_last_of_block (o_last_of_block)
    );

endmodule
